/* rtl/imuq_pkg.sv */
// shared types, constants and lookup functions for the imu frame euler unit
package imuq_pkg;

  localparam int MIN_FRAME = 29;
  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] RATE_CODE = 8'h03;
  localparam logic [7:0] QUAT_CODE = 8'h02;

  // cordic input width and angle accumulator width (2^-16 degree)
  localparam int CW = 34;
  localparam int ZW = 26;

  typedef struct packed {
    logic             ok;
    logic             rate_upd;
    logic             quat_upd;
    logic [15:0]      pitch_raw;
    logic [15:0]      yaw_raw;
    logic [3:0][15:0] quat;
  } job_t;

  typedef struct packed {
    logic               header_ok;
    logic signed [14:0] yaw;
    logic signed [13:0] pitch;
    logic signed [14:0] roll;
    logic signed [31:0] yaw_sum;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
  } result_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // -raw * 125/128, rounded half away from zero
  function automatic logic signed [15:0] rate_of(input logic [15:0] raw);
    logic signed [23:0] n;
    logic [22:0]        mag;
    logic [15:0]        m;
    n   = -(24'(signed'(raw)) * 24'sd125);
    mag = n[23] ? 23'(-n) : n[22:0];
    m   = 16'((mag + 23'd64) >> 7);
    return n[23] ? -signed'(m) : signed'(m);
  endfunction

endpackage

/* rtl/imuq_fifo.sv */
// small synchronous fifo used for the job and result queues
module imuq_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* rtl/imuq_front.sv */
// byte capture, frame length and header check, job building
module imuq_front #(
  parameter int FRAME_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_frame_byte,
  input  logic          in_end_of_frame,
  output logic          in_full,
  input  logic          jq_full,
  output logic          jq_push,
  output imuq_pkg::job_t jq_data
);
  import imuq_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]       cap_r   [MIN_FRAME];
  logic [7:0]       cap_nxt [MIN_FRAME];
  logic             accept;

  assign accept  = in_push & ~jq_full;
  assign in_full = jq_full;
  assign jq_push = accept & in_end_of_frame;
  assign cnt_inc = (cnt_r < CNT_W'(FRAME_BYTES)) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    cap_nxt = cap_r;
    if (accept && cnt_r < CNT_W'(MIN_FRAME)) begin
      cap_nxt[cnt_r[4:0]] = in_frame_byte;
    end
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_end_of_frame ? '0 : cnt_inc;
    end
  end

  // job fields see the byte arriving in this cycle
  always_comb begin
    jq_data.ok = (cnt_inc >= CNT_W'(MIN_FRAME)) && (cap_nxt[0] == HDR_BYTE) &&
                 (cap_nxt[1] == HDR_BYTE);
    jq_data.rate_upd  = (cap_nxt[15] == RATE_CODE);
    jq_data.quat_upd  = (cap_nxt[2] == QUAT_CODE);
    jq_data.pitch_raw = {cap_nxt[26], cap_nxt[25]};
    jq_data.yaw_raw   = {cap_nxt[28], cap_nxt[27]};
    for (int j = 0; j < 4; j++) begin
      jq_data.quat[j] = {cap_nxt[5 + 2 * j], cap_nxt[4 + 2 * j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r <= cap_nxt;
  end

endmodule

/* rtl/imuq_cordic.sv */
// vectoring cordic, one micro-rotation per cycle, angle in 2^-16 degree
module imuq_cordic #(
  parameter int STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [imuq_pkg::CW-1:0] x_in,
  input  logic signed [imuq_pkg::CW-1:0] y_in,
  output logic                           done,
  output logic signed [imuq_pkg::ZW-1:0] z_out
);
  import imuq_pkg::*;

  localparam int W  = CW + 3;
  localparam int IW = $clog2(STEPS);
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

  logic signed [W-1:0]  x_r, y_r, xe, ye, dx, dy;
  logic signed [ZW-1:0] z_r, ang;
  logic [IW-1:0]        i_r;
  logic                 run_r, done_r;

  assign xe    = W'(x_in);
  assign ye    = W'(y_in);
  assign dx    = x_r >>> i_r;
  assign dy    = y_r >>> i_r;
  assign ang   = atan_tab(5'(i_r));
  assign done  = done_r;
  assign z_out = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (xe == '0 && ye == '0) begin
          z_r    <= '0;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          // bring the vector into the right half plane
          if (xe < 0) begin
            if (ye >= 0) begin
              x_r <= ye;
              y_r <= -xe;
              z_r <= DEG90;
            end else begin
              x_r <= -ye;
              y_r <= xe;
              z_r <= -DEG90;
            end
          end else begin
            x_r <= xe;
            y_r <= ye;
            z_r <= '0;
          end
        end
      end else if (run_r) begin
        if (y_r > 0) begin
          x_r <= x_r + dy;
          y_r <= y_r - dx;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - dy;
          y_r <= y_r + dx;
          z_r <= z_r - ang;
        end
        if (i_r == IW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/imuq_back.sv */
// per-frame sequencer: products, square root, three cordic runs, unwrap
module imuq_back #(
  parameter int STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              unwrap_en,
  input  logic              jq_empty,
  input  imuq_pkg::job_t    jq_data,
  output logic              jq_pop,
  input  logic              oq_full,
  output logic              oq_push,
  output imuq_pkg::result_t oq_data
);
  import imuq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_FORM  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_RT0   = 4'd4;
  localparam logic [3:0] S_RT    = 4'd5;
  localparam logic [3:0] S_CSET  = 4'd6;
  localparam logic [3:0] S_CWAIT = 4'd7;
  localparam logic [3:0] S_UNW   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;

  localparam logic [1:0] A_YAW   = 2'd0;
  localparam logic [1:0] A_ROLL  = 2'd1;
  localparam logic [1:0] A_PITCH = 2'd2;

  localparam logic signed [CW-1:0] ONE_Q30  = CW'(1) <<< 30;
  localparam logic signed [16:0]   UNW_THR  = 17'sd6400;
  localparam logic signed [16:0]   TURN     = 17'sd23040;
  localparam logic signed [ZW-1:0] LIM_WIDE = ZW'(11520);
  localparam logic signed [ZW-1:0] LIM_HALF = ZW'(5760);

  logic [3:0]          state_r;
  logic [3:0]          k_r;
  logic [1:0]          ai_r;
  logic signed [15:0]  quat_r [4];
  logic signed [15:0]  rate_r [2];
  logic signed [14:0]  prev_r;
  logic signed [31:0]  total_r;
  logic signed [31:0]  prod_r [9];
  logic signed [CW-1:0] ax_r [3];
  logic signed [CW-1:0] ay_r [3];
  logic [30:0]         sa_r;
  logic [61:0]         sq_r;
  logic [60:0]         n_r, r_r, b_r, rt_r_nxt;
  logic [61:0]         rb;
  logic                rt_take;
  logic signed [14:0]  ang_r [3];
  result_t             res_r;

  logic signed [15:0]  ma, mb;
  logic signed [31:0]  mprod;
  logic signed [CW-1:0] yy, yx, ry, rx, sv, s_cl;
  logic                c_start, c_done;
  logic signed [ZW-1:0] c_z, zr, lim, zcl;
  logic signed [14:0]  ang_val;
  logic signed [14:0]  yaw;
  logic signed [16:0]  d0, dlt;
  logic signed [33:0]  tsum;
  logic signed [31:0]  tsat, total_new;

  assign jq_pop  = (state_r == S_IDLE) & ~jq_empty;
  assign oq_push = (state_r == S_PUSH) & ~oq_full;
  assign oq_data = res_r;
  assign c_start = (state_r == S_CSET);

  // one shared 16x16 multiplier walks the nine products
  always_comb begin
    unique case (k_r)
      4'd0: begin ma = quat_r[1]; mb = quat_r[2]; end
      4'd1: begin ma = quat_r[0]; mb = quat_r[3]; end
      4'd2: begin ma = quat_r[2]; mb = quat_r[2]; end
      4'd3: begin ma = quat_r[3]; mb = quat_r[3]; end
      4'd4: begin ma = quat_r[2]; mb = quat_r[3]; end
      4'd5: begin ma = quat_r[0]; mb = quat_r[1]; end
      4'd6: begin ma = quat_r[1]; mb = quat_r[1]; end
      4'd7: begin ma = quat_r[0]; mb = quat_r[2]; end
      4'd8: begin ma = quat_r[1]; mb = quat_r[3]; end
      default: begin ma = '0; mb = '0; end
    endcase
    mprod = ma * mb;
  end

  always_comb begin
    yy = (CW'(prod_r[0]) + CW'(prod_r[1])) <<< 1;
    yx = ONE_Q30 - ((CW'(prod_r[2]) + CW'(prod_r[3])) <<< 1);
    ry = (CW'(prod_r[4]) + CW'(prod_r[5])) <<< 1;
    rx = ONE_Q30 - ((CW'(prod_r[6]) + CW'(prod_r[2])) <<< 1);
    sv = (CW'(prod_r[7]) - CW'(prod_r[8])) <<< 1;
    if (sv > ONE_Q30) begin
      s_cl = ONE_Q30;
    end else if (sv < -ONE_Q30) begin
      s_cl = -ONE_Q30;
    end else begin
      s_cl = sv;
    end
  end

  // bitwise integer square root step
  always_comb begin
    rb      = 62'(r_r) + 62'(b_r);
    rt_take = ({1'b0, n_r} >= rb);
    rt_r_nxt = rt_take ? (r_r >> 1) + b_r : r_r >> 1;
  end

  imuq_cordic #(
    .STEPS (STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .x_in  (ax_r[ai_r]),
    .y_in  (ay_r[ai_r]),
    .done  (c_done),
    .z_out (c_z)
  );

  // round to 1/64 degree, clamp, negate yaw and pitch
  always_comb begin
    zr  = (c_z + ZW'(512)) >>> 10;
    lim = (ai_r == A_PITCH) ? LIM_HALF : LIM_WIDE;
    if (zr > lim) begin
      zcl = lim;
    end else if (zr < -lim) begin
      zcl = -lim;
    end else begin
      zcl = zr;
    end
    ang_val = (ai_r == A_ROLL) ? 15'(zcl) : 15'(-zcl);
  end

  always_comb begin
    yaw = ang_r[A_YAW];
    d0  = 17'(yaw) - 17'(prev_r);
    if (17'(yaw) < -UNW_THR && 17'(prev_r) > UNW_THR) begin
      dlt = d0 + TURN;
    end else if (17'(yaw) > UNW_THR && 17'(prev_r) < -UNW_THR) begin
      dlt = d0 - TURN;
    end else begin
      dlt = d0;
    end
    tsum = 34'(total_r) + 34'(dlt);
    if (tsum > 34'sh07FFFFFFF) begin
      tsat = 32'sh7FFFFFFF;
    end else if (tsum < -34'sh080000000) begin
      tsat = 32'sh80000000;
    end else begin
      tsat = 32'(tsum);
    end
    total_new = unwrap_en ? tsat : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      ai_r    <= A_YAW;
      for (int j = 0; j < 4; j++) begin
        quat_r[j] <= '0;
      end
      rate_r[0] <= '0;
      rate_r[1] <= '0;
      prev_r    <= '0;
      total_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!jq_empty) begin
            if (!jq_data.ok) begin
              res_r   <= '0;
              state_r <= S_PUSH;
            end else begin
              if (jq_data.rate_upd) begin
                rate_r[0] <= rate_of(jq_data.pitch_raw);
                rate_r[1] <= rate_of(jq_data.yaw_raw);
              end
              if (jq_data.quat_upd) begin
                for (int j = 0; j < 4; j++) begin
                  quat_r[j] <= signed'(jq_data.quat[j]);
                end
              end
              k_r     <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r[k_r] <= mprod;
          if (k_r == 4'd8) begin
            state_r <= S_FORM;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FORM: begin
          ax_r[A_YAW]   <= yx;
          ay_r[A_YAW]   <= yy;
          ax_r[A_ROLL]  <= rx;
          ay_r[A_ROLL]  <= ry;
          ay_r[A_PITCH] <= s_cl;
          sa_r          <= 31'(s_cl < 0 ? -s_cl : s_cl);
          state_r       <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= 62'(sa_r) * 62'(sa_r);
          state_r <= S_RT0;
        end
        S_RT0: begin
          n_r     <= (61'(1) << 60) - sq_r[60:0];
          r_r     <= '0;
          b_r     <= 61'(1) << 60;
          state_r <= S_RT;
        end
        S_RT: begin
          if (rt_take) begin
            n_r <= n_r - rb[60:0];
          end
          r_r <= rt_r_nxt;
          b_r <= b_r >> 2;
          if (b_r == 61'd1) begin
            ax_r[A_PITCH] <= CW'(rt_r_nxt);
            ai_r          <= A_YAW;
            state_r       <= S_CSET;
          end
        end
        S_CSET: begin
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (c_done) begin
            ang_r[ai_r] <= ang_val;
            if (ai_r == A_PITCH) begin
              state_r <= S_UNW;
            end else begin
              ai_r    <= ai_r + 1'b1;
              state_r <= S_CSET;
            end
          end
        end
        S_UNW: begin
          total_r          <= total_new;
          prev_r           <= yaw;
          res_r.header_ok  <= 1'b1;
          res_r.yaw        <= yaw;
          res_r.pitch      <= 14'(ang_r[A_PITCH]);
          res_r.roll       <= ang_r[A_ROLL];
          res_r.yaw_sum    <= total_new;
          res_r.pitch_rate <= rate_r[0];
          res_r.yaw_rate   <= rate_r[1];
          state_r          <= S_PUSH;
        end
        S_PUSH: begin
          if (!oq_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/imu_frame_quaternion_to_euler_unit.sv */
// top level of the imu frame decoder with quaternion to euler conversion
//
// input channel: one received byte per transaction (in_frame_byte), with
// in_end_of_frame marking the last byte; a byte is taken when in_push is
// high and in_full is low. bytes stream in at one per cycle unless in_full
// is high; it rises only when two finished frames already wait for the back end.
// result channel: one transaction per frame, shown while out_empty is low
// and taken with out_pop. a short or bad frame gives header_ok low and all
// other fields zero.
// the time from the end-of-frame byte to its result is set by the serial
// multiplier pass, the 31-step square root and three cordic runs on the one
// shared rotator; one frame is worked on at a time, so the back end takes no
// new job before the last result is queued.
// the config channel (cfg_valid/cfg_ready) writes unwrap_enable; it is
// always ready and is meant to be written while the block is idle.
// reset (rst_n low, synchronous) empties both queues, clears the stored
// quaternion, rates, last yaw and yaw sum, and clears unwrap_enable.
// a stalled receiver fills the result queue, then the job queue, then
// raises in_full.
module imu_frame_quaternion_to_euler_unit #(
  parameter int FRAME_BYTES  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_frame_byte,
  input  logic               in_end_of_frame,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_header_ok,
  output logic signed [14:0] out_yaw_angle,
  output logic signed [13:0] out_pitch,
  output logic signed [14:0] out_roll,
  output logic signed [31:0] out_yaw_sum,
  output logic signed [15:0] out_pitch_rate,
  output logic signed [15:0] out_yaw_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_unwrap_enable
);
  import imuq_pkg::*;

  logic    unwrap_r;
  logic    jq_push, jq_full, jq_pop, jq_empty;
  job_t    jq_in, jq_out;
  logic    oq_push, oq_full;
  result_t oq_in, oq_out;

  // config register, taken on any completed write transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unwrap_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unwrap_r <= cfg_unwrap_enable;
    end
  end

  // front end: byte capture and frame checks
  imuq_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_frame_byte   (in_frame_byte),
    .in_end_of_frame (in_end_of_frame),
    .in_full         (in_full),
    .jq_full         (jq_full),
    .jq_push         (jq_push),
    .jq_data         (jq_in)
  );

  // two-frame job queue decouples capture from the maths
  imuq_fifo #(
    .W     ($bits(job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .din   (jq_in),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_out),
    .empty (jq_empty)
  );

  // back end: quaternion maths and yaw unwrap
  imuq_back #(
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .unwrap_en (unwrap_r),
    .jq_empty  (jq_empty),
    .jq_data   (jq_out),
    .jq_pop    (jq_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_data   (oq_in)
  );

  // result queue keeps the back end running while the receiver stalls
  imuq_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_in),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_out),
    .empty (out_empty)
  );

  assign out_header_ok  = oq_out.header_ok;
  assign out_yaw_angle  = oq_out.yaw;
  assign out_pitch      = oq_out.pitch;
  assign out_roll       = oq_out.roll;
  assign out_yaw_sum    = oq_out.yaw_sum;
  assign out_pitch_rate = oq_out.pitch_rate;
  assign out_yaw_rate   = oq_out.yaw_rate;

endmodule

/* rtl/imuq_checker.sv */
// port-level checks for the imu frame euler unit, bound to the top level
module imuq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic               out_header_ok,
  input logic signed [14:0] out_yaw_angle,
  input logic signed [13:0] out_pitch,
  input logic signed [14:0] out_roll,
  input logic signed [31:0] out_yaw_sum,
  input logic signed [15:0] out_pitch_rate,
  input logic signed [15:0] out_yaw_rate
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // a rejected frame carries only zeros
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_header_ok) |->
      (out_yaw_angle == 0 && out_pitch == 0 && out_roll == 0 &&
       out_yaw_sum == 0 && out_pitch_rate == 0 && out_yaw_rate == 0))
    else $error("rejected frame with non-zero fields");

  // angles stay inside their clamp limits
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      (out_yaw_angle <= 15'sd11520 && out_yaw_angle >= -15'sd11520 &&
       out_roll <= 15'sd11520 && out_roll >= -15'sd11520 &&
       out_pitch <= 14'sd5760 && out_pitch >= -14'sd5760))
    else $error("angle outside clamp range");

  // a result not taken stays in place
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_yaw_sum) &&
      $stable(out_yaw_angle)))
    else $error("waiting result changed");

endmodule

bind imu_frame_quaternion_to_euler_unit imuq_checker u_imuq_checker (.*);

/* verif/imu_frame_quaternion_to_euler_unit_tb.sv */
// testbench for the imu frame decoder with quaternion to euler conversion
`timescale 1ns / 100ps

class euler_scoreboard;
  imuq_pkg::result_t expected_q[$];
  int unsigned errors;
  bit unwrap_en;

  byte unsigned frame_buf[32];
  int unsigned  fill;
  shortint      quat[4];
  int           pitch_rate, yaw_rate;
  int           last_yaw;
  int           yaw_total;

  // atan(2^-i) in 2^-16 degree
  longint arc_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};

  function new();
    errors = 0;
    unwrap_en = 0;
    fill = 0;
    foreach (quat[i]) quat[i] = 0;
    pitch_rate = 0;
    yaw_rate = 0;
    last_yaw = 0;
    yaw_total = 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring rotation, angle in 2^-16 degree
  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy; y = y - dx; z = z + arc_tab[i];
      end else begin
        x = x - dy; y = y + dx; z = z - arc_tab[i];
      end
    end
    return z;
  endfunction

  function automatic int deg64(longint z, int lim);
    longint r;
    r = (z + 512) >>> 10;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return int'(r);
  endfunction

  function automatic int scale_rate(byte unsigned lo, byte unsigned hi);
    int raw, n;
    raw = int'(shortint'({hi, lo}));
    n = -raw * 125;
    if (n >= 0) return (n + 64) / 128;
    return -((-n + 64) / 128);
  endfunction

  // accepted input byte; a finished frame pushes its expected result
  function void note_byte(byte unsigned b, bit eof);
    imuq_pkg::result_t r;
    longint q0, q1, q2, q3, s, c, sum, delta;
    longint unsigned sa;
    int yaw, pitch, roll, len;
    if (fill < 32) begin
      frame_buf[fill] = b;
      fill++;
    end
    if (!eof) return;
    len = fill;
    fill = 0;
    r = '0;
    if (len < 29 || frame_buf[0] != imuq_pkg::HDR_BYTE || frame_buf[1] != imuq_pkg::HDR_BYTE)
    begin
      expected_q.push_back(r);
      return;
    end
    if (frame_buf[15] == imuq_pkg::RATE_CODE) begin
      pitch_rate = scale_rate(frame_buf[25], frame_buf[26]);
      yaw_rate   = scale_rate(frame_buf[27], frame_buf[28]);
    end
    if (frame_buf[2] == imuq_pkg::QUAT_CODE)
      for (int j = 0; j < 4; j++) quat[j] = shortint'({frame_buf[5+2*j], frame_buf[4+2*j]});
    q0 = quat[0]; q1 = quat[1]; q2 = quat[2]; q3 = quat[3];
    yaw  = -deg64(vector_angle(2 * (q1 * q2 + q0 * q3),
                               (64'sd1 << 30) - 2 * (q2 * q2 + q3 * q3)), 11520);
    roll =  deg64(vector_angle(2 * (q2 * q3 + q0 * q1),
                               (64'sd1 << 30) - 2 * (q1 * q1 + q2 * q2)), 11520);
    s = 2 * (q0 * q2 - q1 * q3);
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
    sa = (s < 0) ? -s : s;
    c = longint'(int_sqrt((64'd1 << 60) - sa * sa));
    pitch = -deg64(vector_angle(s, c), 5760);
    if (unwrap_en) begin
      // jump across the +-180 seam gets a full turn of correction
      if (yaw < -6400 && last_yaw > 6400) delta = 23040 + longint'(yaw) - last_yaw;
      else if (yaw > 6400 && last_yaw < -6400) delta = -23040 + longint'(yaw) - last_yaw;
      else delta = longint'(yaw) - last_yaw;
      sum = longint'(yaw_total) + delta;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      yaw_total = int'(sum);
    end
    last_yaw = yaw;
    r.header_ok  = 1'b1;
    r.yaw        = yaw[14:0];
    r.pitch      = pitch[13:0];
    r.roll       = roll[14:0];
    r.yaw_sum    = yaw_total;
    r.pitch_rate = pitch_rate[15:0];
    r.yaw_rate   = yaw_rate[15:0];
    expected_q.push_back(r);
  endfunction

  function void field_cmp(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
    end
  endfunction

  function void check_result(imuq_pkg::result_t act);
    imuq_pkg::result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual header_ok %0d",
               $time, act.header_ok);
      return;
    end
    e = expected_q.pop_front();
    field_cmp("header_ok", e.header_ok, act.header_ok);
    field_cmp("yaw_angle", e.yaw, act.yaw);
    field_cmp("pitch", e.pitch, act.pitch);
    field_cmp("roll", e.roll, act.roll);
    field_cmp("yaw_sum", e.yaw_sum, act.yaw_sum);
    field_cmp("pitch_rate", e.pitch_rate, act.pitch_rate);
    field_cmp("yaw_rate", e.yaw_rate, act.yaw_rate);
  endfunction
endclass

module imu_frame_quaternion_to_euler_unit_tb;
  import imuq_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_frame_byte = '0;
  logic               in_end_of_frame = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_header_ok;
  logic signed [14:0] out_yaw_angle;
  logic signed [13:0] out_pitch;
  logic signed [14:0] out_roll;
  logic signed [31:0] out_yaw_sum;
  logic signed [15:0] out_pitch_rate;
  logic signed [15:0] out_yaw_rate;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_unwrap_enable = 1'b0;

  euler_scoreboard sb = new();
  bit          idle_on = 1'b1;     // random gaps on both sides
  bit          long_hold_req = 1'b0;
  int unsigned bytes_sent = 0;

  always #5 clk = ~clk;

  imu_frame_quaternion_to_euler_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_frame_byte(in_frame_byte), .in_end_of_frame(in_end_of_frame),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_header_ok(out_header_ok), .out_yaw_angle(out_yaw_angle),
    .out_pitch(out_pitch), .out_roll(out_roll),
    .out_yaw_sum(out_yaw_sum), .out_pitch_rate(out_pitch_rate),
    .out_yaw_rate(out_yaw_rate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_unwrap_enable(cfg_unwrap_enable)
  );

  // result side: check every popped transaction, stall in random bursts
  always @(posedge clk) begin
    int unsigned stall_left;
    result_t act;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        act = '{out_header_ok, out_yaw_angle, out_pitch, out_roll,
                out_yaw_sum, out_pitch_rate, out_yaw_rate};
        sb.check_result(act);
      end
      if (long_hold_req) begin
        // long hold so that the result and job queues fill and in_full rises
        long_hold_req <= 1'b0;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // one byte transaction, with an occasional gap in front of it
  task automatic send_byte(input byte unsigned b, input bit eof);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_frame_byte <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_full);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte unsigned fb[$]);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  // well-formed frame with the given codes, quaternion and raw rates
  task automatic send_imu_frame(input int len, input bit quat_code, input bit rate_code,
                                input shortint q[4], input shortint pr, input shortint yr);
    byte unsigned fb[$];
    for (int i = 0; i < len; i++) fb.push_back(byte'($urandom));
    fb[0] = HDR_BYTE;
    fb[1] = HDR_BYTE;
    fb[2] = quat_code ? QUAT_CODE : byte'($urandom_range(3, 255));
    fb[15] = rate_code ? RATE_CODE : byte'($urandom_range(4, 255));
    for (int j = 0; j < 4; j++) begin
      fb[4+2*j] = q[j][7:0];
      fb[5+2*j] = q[j][15:8];
    end
    fb[25] = pr[7:0]; fb[26] = pr[15:8];
    fb[27] = yr[7:0]; fb[28] = yr[15:8];
    send_frame(fb);
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // config write only with the block idle; allow for the back end latency
  task automatic write_unwrap(input bit v);
    drain();
    repeat (160) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_unwrap_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.unwrap_en = v;
  endtask

  task automatic random_phase(input int unsigned target);
    shortint q[4];
    byte unsigned fb[$];
    int kind, len;
    while (bytes_sent < target) begin
      kind = $urandom_range(0, 99);
      foreach (q[j]) q[j] = shortint'($urandom);
      if (kind < 80) begin
        // mostly full frames; a few overlong ones get truncated
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(29, 32);
        send_imu_frame(len, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0, q,
                       shortint'($urandom), shortint'($urandom));
      end else begin
        fb.delete();
        len = (kind < 90) ? $urandom_range(1, 28) : $urandom_range(29, 34);
        for (int i = 0; i < len; i++) fb.push_back(byte'($urandom));
        if (kind < 90 && $urandom_range(0, 1)) begin
          fb[0] = HDR_BYTE;
          if (len > 1) fb[1] = HDR_BYTE;
        end else if (kind >= 90 && $urandom_range(0, 1)) begin
          fb[0] = HDR_BYTE;   // one good header byte only
        end
        send_frame(fb);
      end
    end
  endtask

  initial begin
    shortint q[4];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_unwrap(1'b1);

    // directed frames: identity, extremes, seam crossings, special cases
    q = '{32767, 0, 0, 0};
    send_imu_frame(29, 1, 1, q, 16'sh8000, 16'sh7fff);
    q = '{0, 0, 0, 32767};             // yaw near 180
    send_imu_frame(32, 1, 1, q, 0, 1);
    q = '{16384, 0, 0, -16384};        // yaw jumps back to +45 degrees without crossing the seam
    send_imu_frame(29, 1, 0, q, 0, 0);
    q = '{-32768, -32768, -32768, -32768};
    send_imu_frame(30, 1, 1, q, -1, 64);
    q = '{0, 0, 16384, 16384};         // atan2 of zero over zero
    send_imu_frame(29, 1, 0, q, 0, 0);
    q = '{32767, 32767, 32767, -32768}; // asin argument beyond one, clamped
    send_imu_frame(29, 1, 0, q, 0, 0);
    q = '{-32768, 32767, -32768, 32767};
    send_imu_frame(29, 1, 0, q, 0, 0);
    q = '{0, 0, 0, 0};
    send_imu_frame(31, 0, 0, q, 0, 0);   // no codes: stored values are held
    send_imu_frame(40, 1, 1, q, 100, -100); // too many bytes
    send_frame('{HDR_BYTE, HDR_BYTE, QUAT_CODE});         // short frame
    send_frame('{8'h00, HDR_BYTE, 8'hff, 8'h55});         // bad header
    send_byte(8'hff, 1'b1);                                // single byte frame

    random_phase(700);
    long_hold_req <= 1'b1;
    random_phase(1000);
    drain();                 // sender waits for every result

    write_unwrap(1'b0);
    random_phase(1350);

    write_unwrap(1'b1);
    idle_on = 1'b0;
    random_phase(1800);
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule
